/* hdl/lsm_pkg.sv */
// Shared types and timing constants for the LCD scanline mode timing block.
// No dependencies; used by lcd_scanline_mode_timing.
package lsm_pkg;

  localparam int unsigned CycW = 9;
  localparam int unsigned DiffW = 11;
  localparam int unsigned LineW = 8;

  typedef logic [CycW-1:0] cyc_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic [LineW-1:0] line_t;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  localparam cyc_t LINE_CYCLES = 9'd456;
  localparam diff_t OAM_THRESHOLD = 11'sd376;
  localparam diff_t XFER_THRESHOLD = 11'sd204;
  localparam line_t VBLANK_LINE = 8'd144;
  localparam line_t LINE_COUNT = 8'd154;

endpackage

/* hdl/lcd_scanline_mode_timing.sv */
// Top level of the LCD scanline mode timing block: line counter, mode select and interrupt flags.
// Depends on lsm_pkg for types and timing constants.
//
// Usage:
// Each input transaction carries the machine cycles elapsed since the previous
// one, the display enable, the line compare value and the three STAT interrupt
// enables. For every input transaction the block returns exactly one result
// transaction with the mode, the current line, the coincidence flag and the
// vblank, STAT and draw-line requests.
// The timing state is updated in the cycle the input transaction is accepted and
// the result is held in an output register, so it appears in the cycle after acceptance.
// Throughput is one transaction per cycle while the receiver takes each result; the single
// subtract and compare path from the state registers to the output register sets that figure.
// While the receiver stalls, the result stays in the output register and the
// input is blocked only when that register is full and not being taken.
// Reset (synchronous, active low) loads the cycle countdown with LINE_CYCLES, line 0 and
// mode 0, and empties the output register.
module lcd_scanline_mode_timing (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_elapsed_cycles,
  input  logic       in_display_enable,
  input  logic [7:0] in_line_compare,
  input  logic       in_hblank_irq_enable,
  input  logic       in_oam_irq_enable,
  input  logic       in_coincidence_irq_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_lcd_mode,
  output logic [7:0] out_current_line,
  output logic       out_coincidence,
  output logic       out_vblank_request,
  output logic       out_stat_request,
  output logic       out_draw_line
);

  lsm_pkg::cyc_t  cycles_r, cycles_nxt;
  lsm_pkg::line_t line_r, line_nxt;
  lsm_pkg::mode_t mode_r, mode_nxt;

  logic           out_valid_r;
  logic           coin_nxt, vblank_nxt, stat_nxt, draw_nxt;
  logic           coin_r, vblank_r, stat_r, draw_r;
  lsm_pkg::diff_t diff;
  lsm_pkg::line_t line_inc;
  logic           want;
  logic           accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  assign diff = lsm_pkg::diff_t'({2'b00, cycles_r}) - lsm_pkg::diff_t'({6'b0, in_elapsed_cycles});
  assign line_inc = line_r + 8'd1;

  always_comb begin
    cycles_nxt = cycles_r;
    line_nxt = line_r;
    mode_nxt = mode_r;
    vblank_nxt = 1'b0;
    draw_nxt = 1'b0;
    want = 1'b0;
    stat_nxt = 1'b0;
    if (in_display_enable) begin
      cycles_nxt = diff[lsm_pkg::CycW-1:0];
      if (line_r >= lsm_pkg::VBLANK_LINE) begin
        mode_nxt = lsm_pkg::MODE_VBLANK;
      end else begin
        if (diff >= lsm_pkg::OAM_THRESHOLD) begin
          mode_nxt = lsm_pkg::MODE_OAM;
          want = in_oam_irq_enable;
        end else if (diff >= lsm_pkg::XFER_THRESHOLD) begin
          mode_nxt = lsm_pkg::MODE_TRANSFER;
        end else begin
          mode_nxt = lsm_pkg::MODE_HBLANK;
          want = in_hblank_irq_enable;
        end
        stat_nxt = want && (mode_nxt != mode_r);
      end
      if (diff <= 11'sd0) begin
        cycles_nxt = lsm_pkg::LINE_CYCLES;
        if (line_inc == lsm_pkg::VBLANK_LINE) begin
          line_nxt = line_inc;
          vblank_nxt = 1'b1;
          mode_nxt = lsm_pkg::MODE_VBLANK;
        end else if (line_inc == lsm_pkg::LINE_COUNT) begin
          line_nxt = '0;
        end else begin
          line_nxt = line_inc;
          draw_nxt = line_inc < lsm_pkg::VBLANK_LINE;
        end
      end
    end else begin
      mode_nxt = lsm_pkg::MODE_VBLANK;
      cycles_nxt = lsm_pkg::LINE_CYCLES;
      line_nxt = '0;
    end
    coin_nxt = (line_nxt == in_line_compare);
    if (coin_nxt && in_coincidence_irq_enable) begin
      stat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycles_r <= lsm_pkg::LINE_CYCLES;
      line_r <= '0;
      mode_r <= lsm_pkg::MODE_HBLANK;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cycles_r <= cycles_nxt;
        line_r <= line_nxt;
        mode_r <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coin_r <= coin_nxt;
      vblank_r <= vblank_nxt;
      stat_r <= stat_nxt;
      draw_r <= draw_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lcd_mode = mode_r;
  assign out_current_line = line_r;
  assign out_coincidence = coin_r;
  assign out_vblank_request = vblank_r;
  assign out_stat_request = stat_r;
  assign out_draw_line = draw_r;

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_r < lsm_pkg::LINE_COUNT)
    else $error("Line counter left the valid range.");

  a_cycles_range: assert property (@(posedge clk) disable iff (!rst_n)
    cycles_r != '0 && cycles_r <= lsm_pkg::LINE_CYCLES)
    else $error("Cycle countdown left the valid range.");

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && vblank_r |-> line_r == lsm_pkg::VBLANK_LINE &&
      mode_r == lsm_pkg::MODE_VBLANK && !draw_r)
    else $error("Vblank request without entering the vblank line.");

  a_draw_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && draw_r |-> line_r != '0 && line_r < lsm_pkg::VBLANK_LINE)
    else $error("Draw-line pulse outside the visible lines.");

endmodule

/* tb/lcd_scanline_mode_timing_test.sv */
// Self-checking testbench for lcd_scanline_mode_timing: line counter, LCD mode and interrupt flags.
// Random valid/ready stalls on both channels; results are checked against an in-bench predictor.
// Depends on lsm_pkg and lcd_scanline_mode_timing.
module lcd_scanline_mode_timing_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [4:0]      elapsed;
    logic            enable;
    lsm_pkg::line_t  compare;
    logic            hblank_en;
    logic            oam_en;
    logic            coin_en;
    logic            drain;
  } lcd_step_t;

  typedef struct packed {
    logic [1:0]      mode;
    lsm_pkg::line_t  line;
    logic            coin;
    logic            vblank;
    logic            stat;
    logic            draw;
  } scan_state_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] in_elapsed_cycles = '0;
  logic       in_display_enable = 1'b0;
  logic [7:0] in_line_compare = '0;
  logic       in_hblank_irq_enable = 1'b0;
  logic       in_oam_irq_enable = 1'b0;
  logic       in_coincidence_irq_enable = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_lcd_mode;
  logic [7:0] out_current_line;
  logic       out_coincidence;
  logic       out_vblank_request;
  logic       out_stat_request;
  logic       out_draw_line;

  lcd_step_t   pending_steps[$];
  scan_state_t expected_scans[$];
  lcd_step_t   step_on_port = '0;
  scan_state_t got_scan;
  scan_state_t want_scan;

  int             cycles_left = lsm_pkg::LINE_CYCLES;
  lsm_pkg::line_t line_no = '0;
  lsm_pkg::mode_t cur_mode = lsm_pkg::MODE_HBLANK;

  int steps_sent = 0;
  int scans_checked = 0;
  int steps_total = 0;
  int mismatches = 0;
  int cycle_count = 0;
  logic calm;

  lcd_scanline_mode_timing dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_elapsed_cycles(in_elapsed_cycles),
    .in_display_enable(in_display_enable),
    .in_line_compare(in_line_compare),
    .in_hblank_irq_enable(in_hblank_irq_enable),
    .in_oam_irq_enable(in_oam_irq_enable),
    .in_coincidence_irq_enable(in_coincidence_irq_enable),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_lcd_mode(out_lcd_mode),
    .out_current_line(out_current_line),
    .out_coincidence(out_coincidence),
    .out_vblank_request(out_vblank_request),
    .out_stat_request(out_stat_request),
    .out_draw_line(out_draw_line)
  );

  always #4 clk = ~clk;

  assign calm = (cycle_count >= 200) && (cycle_count < 450);

  function automatic scan_state_t advance_scanline(lcd_step_t s);
    scan_state_t r;
    lsm_pkg::mode_t prev;
    logic want;
    r = '0;
    if (s.enable) begin
      cycles_left = cycles_left - int'(s.elapsed);
      if (line_no >= lsm_pkg::VBLANK_LINE) begin
        cur_mode = lsm_pkg::MODE_VBLANK;
      end else begin
        prev = cur_mode;
        want = 1'b0;
        if (cycles_left >= lsm_pkg::OAM_THRESHOLD) begin
          cur_mode = lsm_pkg::MODE_OAM;
          want = s.oam_en;
        end else if (cycles_left >= lsm_pkg::XFER_THRESHOLD) begin
          cur_mode = lsm_pkg::MODE_TRANSFER;
        end else begin
          cur_mode = lsm_pkg::MODE_HBLANK;
          want = s.hblank_en;
        end
        if (want && prev != cur_mode) r.stat = 1'b1;
      end
      if (cycles_left <= 0) begin
        line_no = line_no + 8'd1;
        cycles_left = lsm_pkg::LINE_CYCLES;
        if (line_no == lsm_pkg::VBLANK_LINE) begin
          r.vblank = 1'b1;
          cur_mode = lsm_pkg::MODE_VBLANK;
        end else begin
          if (line_no < lsm_pkg::VBLANK_LINE) r.draw = 1'b1;
          if (line_no >= lsm_pkg::LINE_COUNT) line_no = '0;
        end
      end
    end else begin
      cur_mode = lsm_pkg::MODE_VBLANK;
      cycles_left = lsm_pkg::LINE_CYCLES;
      line_no = '0;
    end
    r.coin = (line_no == s.compare);
    if (r.coin && s.coin_en) r.stat = 1'b1;
    r.mode = cur_mode;
    r.line = line_no;
    return r;
  endfunction

  task automatic add_step(input int elapsed, input bit enable, input int compare,
                          input bit hblank_en, input bit oam_en, input bit coin_en,
                          input bit drain = 1'b0);
    lcd_step_t s;
    s.elapsed = elapsed[4:0];
    s.enable = enable;
    s.compare = compare[7:0];
    s.hblank_en = hblank_en;
    s.oam_en = oam_en;
    s.coin_en = coin_en;
    s.drain = drain;
    pending_steps.push_back(s);
    steps_total++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_scans.push_back(advance_scanline(step_on_port));
        steps_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_steps.size() != 0
            && !(pending_steps[0].drain && steps_sent != scans_checked)
            && (calm || $urandom_range(99) >= 26)) begin
          step_on_port = pending_steps.pop_front();
          in_valid <= 1'b1;
          in_elapsed_cycles <= step_on_port.elapsed;
          in_display_enable <= step_on_port.enable;
          in_line_compare <= step_on_port.compare;
          in_hblank_irq_enable <= step_on_port.hblank_en;
          in_oam_irq_enable <= step_on_port.oam_en;
          in_coincidence_irq_enable <= step_on_port.coin_en;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_scan = {out_lcd_mode, out_current_line, out_coincidence, out_vblank_request,
                    out_stat_request, out_draw_line};
        if (expected_scans.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, actual %h", $time, got_scan);
          mismatches++;
        end else begin
          want_scan = expected_scans.pop_front();
          check_field("lcd_mode", want_scan.mode, got_scan.mode);
          check_field("current_line", want_scan.line, got_scan.line);
          check_field("coincidence", want_scan.coin, got_scan.coin);
          check_field("vblank_request", want_scan.vblank, got_scan.vblank);
          check_field("stat_request", want_scan.stat, got_scan.stat);
          check_field("draw_line", want_scan.draw, got_scan.draw);
        end
        scans_checked <= scans_checked + 1;
      end
      out_ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    add_step(0, 0, 0, 0, 0, 1);
    add_step(0, 1, 255, 0, 1, 0);
    repeat (3) add_step(24, 1, 1, 0, 1, 1);
    add_step(24, 1, 200, 1, 0, 0);
    repeat (7) add_step(24, 1, 0, 1, 0, 0);
    repeat (8) add_step(24, 1, 1, 0, 1, 1);
    add_step(0, 0, 1, 1, 1, 1);
    add_step(16, 1, 0, 1, 1, 1);

    repeat (280) begin
      add_step($urandom_range(24), $urandom_range(99) >= 5,
               ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255),
               $urandom_range(1), $urandom_range(1), $urandom_range(1));
    end

    // A run of long steps from line 0 crosses several line boundaries.
    add_step(0, 0, 0, 1, 1, 1, 1'b1);
    repeat (100) begin
      add_step(($urandom_range(99) < 90) ? $urandom_range(24, 20) : $urandom_range(24), 1,
               ($urandom_range(99) < 70) ? $urandom_range(6) : $urandom_range(255),
               $urandom_range(1), $urandom_range(1), $urandom_range(1));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (scans_checked < steps_total) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_scans.size() != 0) begin
      $display("%0t ns: %0d expected transactions never arrived", $time,
               expected_scans.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lsm_pkg.sv
hdl/lcd_scanline_mode_timing.sv
tb/lcd_scanline_mode_timing_test.sv
